// ===== src/lpsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Low-precision Sun position: shared definitions
// Fixed-point formats, series constants, CORDIC tables and the queue word.
// ----------------------------------------------------------------------------
package lpsp_pkg;

  // Angles are kept to this many bits of a turn.
  localparam int ANGLE_BITS = 32;

  localparam int EPOCH_W = 41;
  localparam int POS_W   = 39;

  // floor(num * 2^64 / den) for num < den < 2^62, evaluated at elaboration.
  function automatic logic [63:0] ratio64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = num;
    for (int i = 0; i < 64; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem  = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // J2000 in units of 2^-24 day.
  localparam logic [63:0] J2000_TICKS = 64'd864773210112;

  // Phase rates in 2^-88 turn per 2^-24 day and offsets in 2^-64 turn.
  localparam logic [63:0] M_RATE = ratio64(64'd999973583, 64'd365250000000);
  localparam logic [63:0] E_RATE = ratio64(64'd130042, 64'd131490000000000);
  localparam logic [63:0] M_OFS  = ratio64(64'd9931267, 64'd10000000);
  localparam logic [63:0] L_OFS  = ratio64(64'd7859444, 64'd10000000);
  localparam logic [63:0] E_OFS  = ratio64(64'd2343929111, 64'd36000000000);

  // J2000 times each rate, modulo 2^88.
  localparam logic [127:0] JM_FULL = 128'(J2000_TICKS) * 128'(M_RATE);
  localparam logic [127:0] JE_FULL = 128'(J2000_TICKS) * 128'(E_RATE);
  localparam logic [87:0]  JM_OFS  = JM_FULL[87:0];
  localparam logic [87:0]  JE_OFS  = JE_FULL[87:0];

  // Keeps the top ANGLE_BITS bits of a 64-bit phase.
  localparam logic [63:0] QMASK = {{ANGLE_BITS{1'b1}}, {(64 - ANGLE_BITS){1'b0}}};

  // Reciprocal of 10125 scaled by 2^64, for the perturbation scaling.
  localparam logic [63:0] K_DIV   = ratio64(64'd1, 64'd10125);
  localparam int          DIV_DEN = 10125;

  // CORDIC.
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // Q30 sine and cosine values.
  typedef logic signed [33:0] q30_t;

  // Position limit in metres.
  localparam logic signed [45:0] POS_LIMIT = 46'sd152200000000;

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [63:0] mp;
    logic [31:0] ep;
  } lpsp_item_t;

  // Back pipeline depth: two CORDIC passes plus arithmetic stages.
  localparam int BACK_LAT = 2 * CORDIC_LAT + 12;

endpackage

// ===== src/lpsp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Low-precision Sun position: front end
// Accepts epochs and forms the mean anomaly and obliquity phases.
// ----------------------------------------------------------------------------
module lpsp_front import lpsp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [EPOCH_W-1:0] in_epoch_mjd,
  output logic               push,
  output lpsp_item_t         push_item,
  input  logic               q_full
);

  logic [3:0]  vf_r;
  logic        en;

  logic [63:0] pm00_r, pm01_r, pe00_r, pe01_r;
  logic [40:0] pm10_r, pm11_r, pe10_r, pe11_r;
  logic [87:0] sm_r, se_r;
  logic [63:0] phm_r, phe_r;
  logic [63:0] mp_r, ep_r;

  // The pipeline moves whenever its last word can leave.
  assign en       = !vf_r[3] || !q_full;
  assign in_ready = en;
  assign push     = vf_r[3] && !q_full;
  assign push_item = '{mp: mp_r, ep: ep_r[63:32]};

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
    end else if (en) begin
      vf_r <= {vf_r[2:0], in_valid};
    end
  end

  // Partial products of the epoch with both rates.
  always_ff @(posedge clk) begin
    if (en) begin
      pm00_r <= 64'(in_epoch_mjd[31:0]) * 64'(M_RATE[31:0]);
      pm01_r <= 64'(in_epoch_mjd[31:0]) * 64'(M_RATE[63:32]);
      pm10_r <= 41'(in_epoch_mjd[40:32]) * 41'(M_RATE[31:0]);
      pm11_r <= 41'(in_epoch_mjd[40:32]) * 41'(M_RATE[63:32]);
      pe00_r <= 64'(in_epoch_mjd[31:0]) * 64'(E_RATE[31:0]);
      pe01_r <= 64'(in_epoch_mjd[31:0]) * 64'(E_RATE[63:32]);
      pe10_r <= 41'(in_epoch_mjd[40:32]) * 41'(E_RATE[31:0]);
      pe11_r <= 41'(in_epoch_mjd[40:32]) * 41'(E_RATE[63:32]);
    end
  end

  // Full products modulo 2^88.
  always_ff @(posedge clk) begin
    if (en) begin
      sm_r <= 88'(pm00_r) + (88'(pm01_r) << 32) + (88'(pm10_r) << 32) + (88'(pm11_r) << 64);
      se_r <= 88'(pe00_r) + (88'(pe01_r) << 32) + (88'(pe10_r) << 32) + (88'(pe11_r) << 64);
    end
  end

  // Time phases: the product taken relative to J2000, floored to 2^-64 turn.
  always_ff @(posedge clk) begin
    if (en) begin
      phm_r <= 64'((sm_r - JM_OFS) >> 24);
      phe_r <= 64'((se_r - JE_OFS) >> 24);
    end
  end

  // Mean anomaly and obliquity, quantized.
  always_ff @(posedge clk) begin
    if (en) begin
      mp_r <= (M_OFS + phm_r) & QMASK;
      ep_r <= (E_OFS - phe_r) & QMASK;
    end
  end

endmodule

// ===== src/lpsp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Low-precision Sun position: phase queue
// A short first-in first-out queue that decouples front and back.
// ----------------------------------------------------------------------------
module lpsp_queue import lpsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lpsp_item_t push_item,
  input  logic       pop,
  output lpsp_item_t head_item,
  output logic       full,
  output logic       empty
);

  lpsp_item_t        mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(Q_DEPTH));
  assign empty     = (count_r == '0);
  assign head_item = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on a write");

endmodule

// ===== src/lpsp_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Low-precision Sun position: CORDIC
// Pipelined rotation giving Q30 cosine and sine of a 32-bit turn fraction.
// ----------------------------------------------------------------------------
module lpsp_cordic import lpsp_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] ang,
  output q30_t        cos_o,
  output q30_t        sin_o
);

  q30_t       x_r [CORDIC_STEPS+1];
  q30_t       y_r [CORDIC_STEPS+1];
  q30_t       z_r [CORDIC_STEPS+1];
  logic [1:0] q_r [CORDIC_STEPS+1];

  logic [31:0] ang_ofs;
  logic [1:0]  quad;
  logic [31:0] red;

  // Reduce to the nearest quadrant.
  always_comb begin
    ang_ofs = ang + 32'h20000000;
    quad    = ang_ofs[31:30];
    red     = ang - {quad, 30'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= 34'($signed(red));
      q_r[0] <= quad;
    end
  end

  // One micro-rotation per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - $signed({2'b00, ATAN_TURN[i]});
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + $signed({2'b00, ATAN_TURN[i]});
        end
        q_r[i+1] <= q_r[i];
      end
    end
  end

  // Map back to the original quadrant.
  always_comb begin
    case (q_r[CORDIC_STEPS])
      2'd0: begin
        cos_o = x_r[CORDIC_STEPS];
        sin_o = y_r[CORDIC_STEPS];
      end
      2'd1: begin
        cos_o = -y_r[CORDIC_STEPS];
        sin_o = x_r[CORDIC_STEPS];
      end
      2'd2: begin
        cos_o = -x_r[CORDIC_STEPS];
        sin_o = -y_r[CORDIC_STEPS];
      end
      default: begin
        cos_o = y_r[CORDIC_STEPS];
        sin_o = -x_r[CORDIC_STEPS];
      end
    endcase
  end

endmodule

// ===== src/lpsp_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Low-precision Sun position: Q30 multiplier
// Two-stage product of a coordinate and a Q30 factor, rounded half away
// from zero.
// ----------------------------------------------------------------------------
module lpsp_mul import lpsp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [39:0] a,
  input  q30_t               b,
  output logic signed [45:0] y
);

  logic [39:0] ua;
  logic [33:0] ub;
  logic        neg_r;
  logic [53:0] phi_r, plo_r;
  logic [74:0] sum;
  logic [44:0] mag;
  logic signed [45:0] y_r;

  // Magnitudes and two partial products.
  always_comb begin
    ua = a[39] ? 40'(-a) : 40'(a);
    ub = b[33] ? 34'(-b) : 34'(b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= a[39] ^ b[33];
      phi_r <= 54'(ua[39:20]) * 54'(ub);
      plo_r <= 54'(ua[19:0]) * 54'(ub);
    end
  end

  // Combine, round and restore the sign.
  always_comb begin
    sum = (75'(phi_r) << 20) + 75'(plo_r) + 75'(1 << 29);
    mag = sum[74:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign y = y_r;

endmodule

// ===== src/lpsp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Low-precision Sun position: back end
// Evaluates the series, rotates into the equatorial frame and saturates.
// ----------------------------------------------------------------------------
module lpsp_back import lpsp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lpsp_item_t             head_item,
  input  logic                   q_empty,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [POS_W-1:0] out_pos_z
);

  typedef struct packed {
    logic [63:0] mp;
    q30_t        ce;
    q30_t        se;
  } side_t;

  typedef struct packed {
    logic signed [39:0] r;
    q30_t               ce;
    q30_t               se;
  } rot_t;

  logic [BACK_LAT-1:0] v_r;
  logic                en;

  q30_t c1, s1, c2, s2, ce, se, cl, sl;
  logic [63:0] md_r [CORDIC_LAT];
  side_t       side_r [7];
  logic signed [39:0] r_r [6];
  logic        neg_r [4];
  logic [50:0] num_r [4];

  logic signed [47:0] n_r;
  logic signed [65:0] acc_r;
  logic [42:0] un;
  logic [49:0] pp_hh_r;
  logic [50:0] pp_hl_r, pp_lh_r;
  logic [51:0] pp_ll_r;
  logic [101:0] psum;
  logic [37:0] qe4_r, qe5_r;
  logic [51:0] prod5_r;
  logic [51:0] rem;
  logic [37:0] qfix;
  logic [63:0] dval;
  logic [63:0] dsh6_r, lp7_r;

  rot_t        rot_r [CORDIC_LAT];
  rot_t        cs_r [2];
  logic signed [45:0] xa, ya, yb, zb;
  logic signed [45:0] xd_r [2];
  logic signed [POS_W-1:0] px_r, py_r, pz_r;

  function automatic logic [POS_W-1:0] sat(input logic signed [45:0] v);
    logic signed [45:0] c;
    c = v;
    if (v > POS_LIMIT) begin
      c = POS_LIMIT;
    end
    if (v < -POS_LIMIT) begin
      c = -POS_LIMIT;
    end
    return c[POS_W-1:0];
  endfunction

  // The whole pipeline advances unless a result waits at the output.
  assign en        = !v_r[BACK_LAT-1] || out_ready;
  assign pop       = !q_empty && en;
  assign out_valid = v_r[BACK_LAT-1];
  assign out_pos_x = px_r;
  assign out_pos_y = py_r;
  assign out_pos_z = pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[BACK_LAT-2:0], pop};
    end
  end

  // First pass: M, 2M and the obliquity.
  lpsp_cordic u_cor_m (.clk(clk), .en(en), .ang(head_item.mp[63:32]), .cos_o(c1), .sin_o(s1));
  lpsp_cordic u_cor_m2 (.clk(clk), .en(en), .ang(head_item.mp[62:31]), .cos_o(c2), .sin_o(s2));
  lpsp_cordic u_cor_e (.clk(clk), .en(en), .ang(head_item.ep), .cos_o(ce), .sin_o(se));

  // Mean anomaly rides alongside the first pass.
  always_ff @(posedge clk) begin
    if (en) begin
      md_r[0] <= head_item.mp;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        md_r[k] <= md_r[k-1];
      end
    end
  end

  // Stage 1: perturbation numerator and distance sum.
  always_ff @(posedge clk) begin
    if (en) begin
      n_r       <= 48'(s1) * 48'sd6892 + 48'(s2) * 48'sd72;
      acc_r     <= 66'(c1) * 66'sd2499000000 + 66'(c2) * 66'sd21000000 + 66'sd536870912;
      side_r[0] <= '{mp: md_r[CORDIC_LAT-1], ce: ce, se: se};
    end
  end

  // Stage 2: distance, and the scaled magnitude to divide.
  assign un = 43'(n_r[47] ? -n_r : n_r);

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]    <= 40'sd149619000000 - 40'(acc_r >>> 30);
      neg_r[0]  <= n_r[47];
      num_r[0]  <= 51'({un, 7'b0}) + 51'd5062;
      side_r[1] <= side_r[0];
    end
  end

  // Stage 3: partial products with the reciprocal.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh_r   <= 50'(num_r[0][50:26]) * 50'(K_DIV[50:26]);
      pp_hl_r   <= 51'(num_r[0][50:26]) * 51'(K_DIV[25:0]);
      pp_lh_r   <= 51'(num_r[0][25:0]) * 51'(K_DIV[50:26]);
      pp_ll_r   <= 52'(num_r[0][25:0]) * 52'(K_DIV[25:0]);
      num_r[1]  <= num_r[0];
      neg_r[1]  <= neg_r[0];
      r_r[1]    <= r_r[0];
      side_r[2] <= side_r[1];
    end
  end

  // Stage 4: quotient estimate.
  assign psum = (102'(pp_hh_r) << 52) + ((102'(pp_hl_r) + 102'(pp_lh_r)) << 26) + 102'(pp_ll_r);

  always_ff @(posedge clk) begin
    if (en) begin
      qe4_r     <= psum[101:64];
      num_r[2]  <= num_r[1];
      neg_r[2]  <= neg_r[1];
      r_r[2]    <= r_r[1];
      side_r[3] <= side_r[2];
    end
  end

  // Stage 5: back-multiply for the correction.
  always_ff @(posedge clk) begin
    if (en) begin
      prod5_r   <= 52'(qe4_r) * 52'(DIV_DEN);
      qe5_r     <= qe4_r;
      num_r[3]  <= num_r[2];
      neg_r[3]  <= neg_r[2];
      r_r[3]    <= r_r[2];
      side_r[4] <= side_r[3];
    end
  end

  // Stage 6: corrected, signed perturbation in place.
  always_comb begin
    rem  = 52'(num_r[3]) - prod5_r;
    qfix = (rem >= 52'(DIV_DEN)) ? 38'(qe5_r + 1'b1) : qe5_r;
    dval = neg_r[3] ? -64'(qfix) : 64'(qfix);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsh6_r    <= dval << 20;
      r_r[4]    <= r_r[3];
      side_r[5] <= side_r[4];
    end
  end

  // Stage 7: ecliptic longitude.
  always_ff @(posedge clk) begin
    if (en) begin
      lp7_r     <= (L_OFS + side_r[5].mp + dsh6_r) & QMASK;
      r_r[5]    <= r_r[4];
      side_r[6] <= side_r[5];
    end
  end

  // Second pass: the longitude.
  lpsp_cordic u_cor_l (.clk(clk), .en(en), .ang(lp7_r[63:32]), .cos_o(cl), .sin_o(sl));

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r[0] <= '{r: r_r[5], ce: side_r[6].ce, se: side_r[6].se};
      for (int k = 1; k < CORDIC_LAT; k++) begin
        rot_r[k] <= rot_r[k-1];
      end
      cs_r[0] <= rot_r[CORDIC_LAT-1];
      cs_r[1] <= cs_r[0];
      xd_r[0] <= xa;
      xd_r[1] <= xd_r[0];
    end
  end

  // Ecliptic vector, then the turn about x by the obliquity.
  lpsp_mul u_mul_x (.clk(clk), .en(en), .a(rot_r[CORDIC_LAT-1].r), .b(cl), .y(xa));
  lpsp_mul u_mul_y (.clk(clk), .en(en), .a(rot_r[CORDIC_LAT-1].r), .b(sl), .y(ya));
  lpsp_mul u_mul_ye (.clk(clk), .en(en), .a(ya[39:0]), .b(cs_r[1].ce), .y(yb));
  lpsp_mul u_mul_ze (.clk(clk), .en(en), .a(ya[39:0]), .b(cs_r[1].se), .y(zb));

  // Output register with saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= sat(xd_r[1]);
      py_r <= sat(yb);
      pz_r <= sat(zb);
    end
  end

endmodule

// ===== src/low_precision_sun_position.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Low-precision Sun position
// Geocentric equatorial Sun position in metres from a fixed-point epoch.
// ----------------------------------------------------------------------------
// The block takes one epoch word per clock while in_ready is high and returns
// one position word per epoch, in order. An epoch passes through the front end,
// a 4-word queue and the back end, whose depth is set by the two passes through
// the 31-stage CORDIC pipelines. While the output is held the queue keeps taking
// words until it is full. No configuration and no state between epochs.
module low_precision_sun_position import lpsp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [EPOCH_W-1:0]      in_epoch_mjd,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [POS_W-1:0] out_pos_z
);

  logic       push, pop, q_full, q_empty;
  lpsp_item_t push_item, head_item;

  lpsp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_epoch_mjd(in_epoch_mjd), .push(push), .push_item(push_item), .q_full(q_full)
  );

  lpsp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item), .pop(pop),
    .head_item(head_item), .full(q_full), .empty(q_empty)
  );

  lpsp_back u_back (
    .clk(clk), .rst_n(rst_n), .head_item(head_item), .q_empty(q_empty), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z)
  );

endmodule
